FILE: rtl/rwu_pkg.sv
// Shared types and constants for the RPROP weight update unit.
`timescale 1ns / 1ps

package rwu_pkg;

    // Item kinds carried on the mode field.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Result outcome codes.
    localparam logic [2:0] OUT_LOADED    = 3'd0;
    localparam logic [2:0] OUT_GROWN     = 3'd1;
    localparam logic [2:0] OUT_SHRUNK    = 3'd2;
    localparam logic [2:0] OUT_STEP      = 3'd3;
    localparam logic [2:0] OUT_READ      = 3'd4;
    localparam logic [2:0] OUT_SATURATED = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEP_INCREASE = 3'd0;
    localparam logic [2:0] REG_STEP_DECREASE = 3'd1;
    localparam logic [2:0] REG_STEP_MAXIMUM  = 3'd2;
    localparam logic [2:0] REG_STEP_MINIMUM  = 3'd3;
    localparam logic [2:0] REG_STEP_INITIAL  = 3'd4;

    // Configuration reset values.
    localparam logic [15:0] RST_STEP_INCREASE = 16'd4915;
    localparam logic [15:0] RST_STEP_DECREASE = 16'd2048;
    localparam logic [30:0] RST_STEP_MAXIMUM  = 31'd838860800;
    localparam logic [30:0] RST_STEP_MINIMUM  = 31'd17;
    localparam logic [30:0] RST_STEP_INITIAL  = 31'd1677722;

    // The step factors are unsigned Q4.12.
    localparam int FACTOR_SHIFT = 12;
    localparam int PROD_W       = 47;

    // One stored entry.
    typedef struct packed {
        logic [31:0] weight;
        logic [30:0] step;
        logic [31:0] change;
    } t_entry;

    // Stage 1: item waiting for its entry to come out of the store.
    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [9:0]  idx;
        logic [31:0] data;
    } t_stage1;

    // Stage 2: sign rule decided, step product formed.
    typedef struct packed {
        logic              valid;
        logic [1:0]        mode;
        logic [9:0]        idx;
        logic              data_pos;
        logic              data_neg;
        logic              grow;
        logic              shrink;
        t_entry            entry;
        logic [PROD_W-1:0] prod;
    } t_stage2;

    // Stage 3: new step and change known, weight sum still to do.
    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [9:0]  idx;
        t_entry      entry;
        logic [2:0]  outcome;
    } t_stage3;

endpackage

FILE: rtl/rprop_weight_update_unit.sv
// RPROP weight store with a four-stage read, scale, clamp and write-back pipeline.
`timescale 1ns / 1ps

// The unit takes one item per clock cycle: a transfer happens at each rising edge
// where start is high and busy is low, and its result appears on the o_ result ports
// with o_result_valid high for exactly one cycle, once the item has passed the stage
// 1, 2 and 3 registers and the result register. The receiver cannot hold results
// off, and none is ever dropped. Each entry lives in a single-port-write,
// registered-read memory, and an item passes through four register stages: store
// read, sign rule and step multiply, step clamp and change, then the saturating weight
// add with write-back. busy rises only when the waiting item is an update or a read of
// an entry that a load or update still in the first three stages will rewrite; it stays
// high until that write-back is done. Items with the unused mode or an index beyond
// the store are taken and give no result. The store is not
// cleared after reset: an entry must be loaded before it is read or updated.
// Configuration writes are always ready and should be made while no item is in flight.
module rprop_weight_update_unit #(
    parameter int ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item command port.
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [9:0]         i_entry_index,
    input  logic signed [31:0] i_data_value,
    // Result port.
    output logic               o_result_valid,
    output logic [9:0]         o_result_index,
    output logic signed [31:0] o_weight_out,
    output logic [30:0]        o_step_out,
    output logic signed [31:0] o_change_out,
    output logic [2:0]         o_outcome,
    // Configuration write port.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rwu_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // Configuration registers.
    logic [15:0] r_step_increase;
    logic [15:0] r_step_decrease;
    logic [30:0] r_step_maximum;
    logic [30:0] r_step_minimum;
    logic [30:0] r_step_initial;

    // Pipeline registers.
    t_stage1 r_s1, n_s1;
    t_stage2 r_s2, n_s2;
    t_stage3 r_s3, n_s3;
    t_entry  r_rd;

    logic        r_out_valid;
    logic [9:0]  r_out_index;
    logic [31:0] r_out_weight;
    logic [30:0] r_out_step;
    logic [31:0] r_out_change;
    logic [2:0]  r_out_outcome;

    t_entry mem [ENTRIES];

    logic          accept;
    logic          item_ok;
    logic          hazard;
    logic [31:0]   in_idx_wide;
    logic [31:0]   wb_idx_wide;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wb_addr;
    logic          wb_en;
    logic          wb_sat;
    t_entry        wb_entry;

    // ------------------------------------------------------------------
    // Configuration port: always ready, unknown indexes are ignored.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_increase <= RST_STEP_INCREASE;
            r_step_decrease <= RST_STEP_DECREASE;
            r_step_maximum  <= RST_STEP_MAXIMUM;
            r_step_minimum  <= RST_STEP_MINIMUM;
            r_step_initial  <= RST_STEP_INITIAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STEP_INCREASE: r_step_increase <= i_cfg_data[15:0];
                REG_STEP_DECREASE: r_step_decrease <= i_cfg_data[15:0];
                REG_STEP_MAXIMUM:  r_step_maximum  <= i_cfg_data[30:0];
                REG_STEP_MINIMUM:  r_step_minimum  <= i_cfg_data[30:0];
                REG_STEP_INITIAL:  r_step_initial  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Issue: filter the item, check for a pending write to the same entry
    // and start the store read.
    // ------------------------------------------------------------------
    assign in_idx_wide = {22'd0, i_entry_index};
    assign rd_addr     = in_idx_wide[AW-1:0];

    // An update or read must see every earlier write to its entry. Writes land at
    // the end of stage 3, so loads and updates in stages 1 to 3 hold it back.
    always_comb begin
        hazard = 1'b0;
        if (i_mode == MODE_UPDATE || i_mode == MODE_READ) begin
            if (r_s1.valid && r_s1.mode != MODE_READ && r_s1.idx == i_entry_index) begin
                hazard = 1'b1;
            end
            if (r_s2.valid && r_s2.mode != MODE_READ && r_s2.idx == i_entry_index) begin
                hazard = 1'b1;
            end
            if (r_s3.valid && r_s3.mode != MODE_READ && r_s3.idx == i_entry_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign busy    = hazard;
    assign accept  = start && !busy;
    assign item_ok = (i_mode == MODE_LOAD || i_mode == MODE_UPDATE || i_mode == MODE_READ)
                     && (in_idx_wide < 32'(ENTRIES));

    always_comb begin
        n_s1.valid = accept && item_ok;
        n_s1.mode  = i_mode;
        n_s1.idx   = i_entry_index;
        n_s1.data  = i_data_value;
    end

    // ------------------------------------------------------------------
    // Stage 1: classify the derivative against the last change and form
    // the step product. A load replaces the entry here.
    // ------------------------------------------------------------------
    always_comb begin
        logic   last_pos;
        logic   last_neg;
        logic   d_pos;
        logic   d_neg;
        logic [15:0] factor;

        last_neg = r_rd.change[31];
        last_pos = !r_rd.change[31] && (|r_rd.change);
        d_neg    = r_s1.data[31];
        d_pos    = !r_s1.data[31] && (|r_s1.data);

        n_s2.valid    = r_s1.valid;
        n_s2.mode     = r_s1.mode;
        n_s2.idx      = r_s1.idx;
        n_s2.data_pos = d_pos;
        n_s2.data_neg = d_neg;
        n_s2.grow     = (last_neg && d_pos) || (last_pos && d_neg);
        n_s2.shrink   = (last_neg && d_neg) || (last_pos && d_pos);

        factor    = n_s2.grow ? r_step_increase : r_step_decrease;
        n_s2.prod = PROD_W'(r_rd.step) * PROD_W'(factor);

        if (r_s1.mode == MODE_LOAD) begin
            n_s2.entry.weight = r_s1.data;
            n_s2.entry.step   = r_step_initial;
            n_s2.entry.change = 32'd0;
        end else begin
            n_s2.entry = r_rd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rescale and clamp the step, work out the change.
    // ------------------------------------------------------------------
    always_comb begin
        logic [30:0] scaled;
        logic [30:0] grown;
        logic [30:0] shrunk;
        logic [31:0] neg_step;

        // The product keeps 35 bits after the Q4.12 shift; anything above 31 saturates.
        if (|r_s2.prod[PROD_W-1:FACTOR_SHIFT+31]) begin
            scaled = 31'h7FFF_FFFF;
        end else begin
            scaled = r_s2.prod[FACTOR_SHIFT+30:FACTOR_SHIFT];
        end
        grown  = (scaled > r_step_maximum) ? r_step_maximum : scaled;
        shrunk = (scaled < r_step_minimum) ? r_step_minimum : scaled;

        n_s3.valid = r_s2.valid;
        n_s3.mode  = r_s2.mode;
        n_s3.idx   = r_s2.idx;
        n_s3.entry = r_s2.entry;
        neg_step   = 32'd0;

        case (r_s2.mode)
            MODE_LOAD: begin
                n_s3.outcome = OUT_LOADED;
            end
            MODE_UPDATE: begin
                if (r_s2.grow) begin
                    n_s3.entry.step = grown;
                    n_s3.outcome    = OUT_GROWN;
                end else if (r_s2.shrink) begin
                    n_s3.entry.step = shrunk;
                    n_s3.outcome    = OUT_SHRUNK;
                end else begin
                    n_s3.outcome    = OUT_STEP;
                end
                // The weight always moves against the derivative; a sign flip or a
                // zero derivative moves it not at all.
                neg_step = ~{1'b0, n_s3.entry.step} + 32'd1;
                if (r_s2.shrink) begin
                    n_s3.entry.change = 32'd0;
                end else if (r_s2.data_pos) begin
                    n_s3.entry.change = neg_step;
                end else if (r_s2.data_neg) begin
                    n_s3.entry.change = {1'b0, n_s3.entry.step};
                end else begin
                    n_s3.entry.change = 32'd0;
                end
            end
            default: begin
                n_s3.outcome = OUT_READ;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 3: saturating weight add, write-back and result register.
    // ------------------------------------------------------------------
    always_comb begin
        logic [32:0] sum;
        logic [31:0] add_change;

        wb_entry   = r_s3.entry;
        wb_sat     = 1'b0;
        add_change = (r_s3.mode == MODE_UPDATE) ? r_s3.entry.change : 32'd0;
        sum        = {r_s3.entry.weight[31], r_s3.entry.weight}
                     + {add_change[31], add_change};

        // The stored change stays the requested one even when the weight clips.
        if (sum[32] != sum[31]) begin
            wb_entry.weight = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            wb_sat          = 1'b1;
        end else begin
            wb_entry.weight = sum[31:0];
        end
    end

    assign wb_idx_wide = {22'd0, r_s3.idx};
    assign wb_addr     = wb_idx_wide[AW-1:0];
    assign wb_en       = r_s3.valid && (r_s3.mode != MODE_READ);

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            mem[wb_addr] <= wb_entry;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_s3.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1.valid  <= n_s1.valid;
            r_s2.valid  <= n_s2.valid;
            r_s3.valid  <= n_s3.valid;
            r_out_valid <= r_s3.valid;
        end
        r_s1.mode <= n_s1.mode;
        r_s1.idx  <= n_s1.idx;
        r_s1.data <= n_s1.data;

        r_s2.mode     <= n_s2.mode;
        r_s2.idx      <= n_s2.idx;
        r_s2.data_pos <= n_s2.data_pos;
        r_s2.data_neg <= n_s2.data_neg;
        r_s2.grow     <= n_s2.grow;
        r_s2.shrink   <= n_s2.shrink;
        r_s2.entry    <= n_s2.entry;
        r_s2.prod     <= n_s2.prod;

        r_s3.mode    <= n_s3.mode;
        r_s3.idx     <= n_s3.idx;
        r_s3.entry   <= n_s3.entry;
        r_s3.outcome <= n_s3.outcome;

        r_out_index  <= r_s3.idx;
        r_out_weight <= wb_entry.weight;
        r_out_step   <= wb_entry.step;
        r_out_change <= wb_entry.change;
        if (wb_sat) begin
            r_out_outcome <= OUT_SATURATED;
        end else begin
            r_out_outcome <= r_s3.outcome;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_weight_out   = r_out_weight;
    assign o_step_out     = r_out_step;
    assign o_change_out   = r_out_change;
    assign o_outcome      = r_out_outcome;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_result_follows_stage3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_s3.valid))
        else $error("result strobe without an item in the last stage");

    a_no_raw_s1_s2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.mode != MODE_LOAD && r_s2.valid && r_s2.mode != MODE_READ)
        |-> (r_s1.idx != r_s2.idx))
        else $error("entry read while an earlier write to it is one stage ahead");

    a_no_raw_s1_s3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.mode != MODE_LOAD && r_s3.valid && r_s3.mode != MODE_READ)
        |-> (r_s1.idx != r_s3.idx))
        else $error("entry read while an earlier write to it is two stages ahead");

    a_load_zero_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_outcome == OUT_LOADED) |-> (o_change_out == 32'sd0))
        else $error("load result with a non-zero change");

endmodule
